>>> sv/lspc_pkg.sv
// Shared types and constants of the laser scan polar-to-cartesian converter.
// Holds the arctangent table, CORDIC gain, register indexes and the command struct.
// No dependencies.
package lspc_pkg;

    // Guard bits carried below the output LSB through the rotation.
    localparam int GUARD_BITS = 16;

    // Inverse CORDIC gain, limiting value, scaled by 2^32.
    localparam logic [31:0] GAIN_INV = 32'd2608131496;

    // Width of the rotation step index (arctangent table depth 32).
    localparam int STEP_W = 5;

    // atan(2^-i) in units of 2^-32 turn.
    localparam logic [31:0] ATAN_TURNS [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
        32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
        32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
        32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] REG_START_ANGLE = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ANGLE_STEP  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_MIN_RANGE   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_MAX_RANGE   = 2'd3;

    // Sequencer to datapath command.
    typedef struct packed {
        logic              load;  // scale range, split angle into quadrant/residual
        logic              rot;   // one micro-rotation
        logic [STEP_W-1:0] step;  // micro-rotation index
    } lspc_cmd_t;

endpackage

>>> sv/lspc_seq.sv
// Sequencer of the converter: walks load, micro-rotations and result hand-off;
// a dropped sample goes straight to hand-off. Depends on lspc_pkg.
module lspc_seq import lspc_pkg::*; #(
    parameter int CORDIC_STEPS = 20
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_fire,
    input  logic       in_keep,
    input  logic       out_free,
    output logic       in_ready,
    output logic       out_load,
    output lspc_cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_LOAD = 4'b0010,
        ST_ROT  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    state_t            state_reg, state_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    state_next = in_keep ? ST_LOAD : ST_DONE;
                end
            end
            ST_LOAD: begin
                state_next = ST_ROT;
                step_next  = '0;
            end
            ST_ROT: begin
                if (step_reg == LAST_STEP) begin
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_load  = (state_reg == ST_DONE) && out_free;
    assign cmd.load  = (state_reg == ST_LOAD);
    assign cmd.rot   = (state_reg == ST_ROT);
    assign cmd.step  = step_reg;

endmodule

>>> sv/lspc_cordic.sv
// Rotation-mode CORDIC datapath: range scaling, one shared micro-rotation
// unit, quadrant fix-up, rounding and saturation. Depends on lspc_pkg.
module lspc_cordic import lspc_pkg::*; #(
    parameter int RANGE_BITS = 20,
    parameter int ANGLE_BITS = 24
) (
    input  logic                   aclk,
    input  lspc_cmd_t              cmd,
    input  logic [RANGE_BITS-1:0]  range_i,
    input  logic [ANGLE_BITS-1:0]  angle_i,
    output logic [RANGE_BITS:0]    point_x,
    output logic [RANGE_BITS:0]    point_y
);

    localparam int XY_W    = RANGE_BITS + GUARD_BITS + 3;
    localparam int RND_W   = XY_W - GUARD_BITS;
    localparam int PROD_W  = RANGE_BITS + 32;
    localparam int A_SHIFT = 32 - ANGLE_BITS;
    localparam logic signed [RND_W-1:0] LIM  = {3'b000, {RANGE_BITS{1'b1}}};
    localparam logic signed [RND_W-1:0] NLIM = -LIM;
    localparam logic signed [XY_W-1:0]  HALF =
        {{(XY_W-GUARD_BITS){1'b0}}, 1'b1, {(GUARD_BITS-1){1'b0}}};

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [32:0]     z_reg;
    logic [1:0]             q_reg;

    logic [PROD_W-1:0]      prod;
    logic [31:0]            a32, a_rnd, res;
    logic signed [XY_W-1:0] dx, dy;
    logic signed [32:0]     t;
    logic signed [XY_W-1:0] vx, vy;

    assign prod  = PROD_W'(range_i) * PROD_W'(GAIN_INV);
    assign a32   = 32'(angle_i) << A_SHIFT;
    assign a_rnd = a32 + 32'h2000_0000;
    assign res   = a32 - {a_rnd[31:30], 30'b0};

    // shared micro-rotation unit
    assign dx = y_reg >>> cmd.step;
    assign dy = x_reg >>> cmd.step;
    assign t  = $signed({1'b0, ATAN_TURNS[cmd.step]});

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x_reg <= $signed(XY_W'(prod >> GUARD_BITS));
            y_reg <= '0;
            z_reg <= $signed({res[31], res});
            q_reg <= a_rnd[31:30];
        end else if (cmd.rot) begin
            if (!z_reg[32]) begin
                x_reg <= x_reg - dx;
                y_reg <= y_reg + dy;
                z_reg <= z_reg - t;
            end else begin
                x_reg <= x_reg + dx;
                y_reg <= y_reg - dy;
                z_reg <= z_reg + t;
            end
        end
    end

    always_comb begin
        case (q_reg)
            2'd0: begin vx = x_reg;  vy = y_reg;  end
            2'd1: begin vx = -y_reg; vy = x_reg;  end
            2'd2: begin vx = -x_reg; vy = -y_reg; end
            default: begin vx = y_reg; vy = -x_reg; end
        endcase
    end

    function automatic logic [RANGE_BITS:0] finish(input logic signed [XY_W-1:0] v);
        logic signed [XY_W-1:0]  s;
        logic signed [RND_W-1:0] r;
        logic signed [RND_W-1:0] c;
        s = v + HALF;
        r = s[XY_W-1:GUARD_BITS];
        if (r > LIM) begin
            c = LIM;
        end else if (r < NLIM) begin
            c = NLIM;
        end else begin
            c = r;
        end
        return c[RANGE_BITS:0];
    endfunction

    assign point_x = finish(vx);
    assign point_y = finish(vy);

endmodule

>>> sv/laser_scan_polar_to_cartesian_top.sv
// Top level of the laser scan polar-to-cartesian converter: configuration
// registers, beam angle tracking, input capture and output register.
// Depends on lspc_pkg, lspc_seq and lspc_cordic.
//
// Usage:
//   Range samples enter on the s_axis beat channel in scan order; tlast marks
//   the last sample of a scan, tuser flags a non-finite sample. Each sample
//   produces exactly one m_axis beat holding x and y; tuser is the valid flag
//   (zero coordinates when the sample was dropped) and tlast copies scan_end.
//   A kept sample is captured, its range is scaled, then it runs through the
//   CORDIC_STEPS micro-rotations of the single shared CORDIC stage; quadrant
//   fix-up, rounding and saturation feed the output register. A dropped sample
//   skips scaling and rotation. s_axis_tready is high only between samples,
//   so a new sample is taken only after the last has reached the output
//   register. The result sits in an output register, so the next sample is
//   accepted while it waits. If m_axis_tready stays low the block finishes the
//   following sample and then holds it until the output register drains.
//   Reset clears the beam offset, restores the register defaults (max range
//   all ones) and empties the output. Configure only while idle.
module laser_scan_polar_to_cartesian_top import lspc_pkg::*; #(
    parameter int RANGE_BITS   = 20,
    parameter int ANGLE_BITS   = 24,
    parameter int CORDIC_STEPS = 20
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // configuration write port
    input  logic                   cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [((ANGLE_BITS > RANGE_BITS) ? ANGLE_BITS : RANGE_BITS)-1:0] cfg_wdata,
    // input samples
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [((RANGE_BITS+7)/8)*8-1:0] s_axis_tdata,  // range_value
    input  logic                   s_axis_tuser,   // not_finite
    input  logic                   s_axis_tlast,   // scan_end
    // output points
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [((2*(RANGE_BITS+1)+7)/8)*8-1:0] m_axis_tdata,  // point_x, point_y
    output logic                   m_axis_tuser,   // point_valid
    output logic                   m_axis_tlast    // point_last
);

    localparam int OUT_TDATA_W = ((2*(RANGE_BITS+1)+7)/8)*8;

    logic [ANGLE_BITS-1:0] start_angle_reg, angle_step_reg, offset_reg, angle_reg;
    logic [RANGE_BITS-1:0] min_range_reg, max_range_reg, range_reg;
    logic                  keep_reg, last_reg;
    logic [RANGE_BITS:0]   out_x_reg, out_y_reg;
    logic                  out_valid_reg, out_keep_reg, out_last_reg;

    logic                  in_fire, in_keep, out_free, out_load;
    logic [RANGE_BITS-1:0] in_range;
    logic [RANGE_BITS:0]   cx, cy;
    lspc_cmd_t             cmd;

    assign in_range = s_axis_tdata[RANGE_BITS-1:0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign in_keep  = !s_axis_tuser && (in_range >= min_range_reg)
                      && (in_range <= max_range_reg);
    assign out_free = !out_valid_reg || m_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_angle_reg <= '0;
            angle_step_reg  <= '0;
            min_range_reg   <= '0;
            max_range_reg   <= '1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_START_ANGLE: start_angle_reg <= cfg_wdata[ANGLE_BITS-1:0];
                REG_ANGLE_STEP:  angle_step_reg  <= cfg_wdata[ANGLE_BITS-1:0];
                REG_MIN_RANGE:   min_range_reg   <= cfg_wdata[RANGE_BITS-1:0];
                REG_MAX_RANGE:   max_range_reg   <= cfg_wdata[RANGE_BITS-1:0];
                default: ;
            endcase
        end
    end

    // beam offset restarts after the last sample of a scan
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= '0;
        end else if (in_fire) begin
            offset_reg <= s_axis_tlast ? '0 : offset_reg + angle_step_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            range_reg <= in_range;
            angle_reg <= start_angle_reg + offset_reg;
            keep_reg  <= in_keep;
            last_reg  <= s_axis_tlast;
        end
    end

    lspc_seq #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_fire  (in_fire),
        .in_keep  (in_keep),
        .out_free (out_free),
        .in_ready (s_axis_tready),
        .out_load (out_load),
        .cmd      (cmd)
    );

    lspc_cordic #(
        .RANGE_BITS (RANGE_BITS),
        .ANGLE_BITS (ANGLE_BITS)
    ) u_cordic (
        .aclk    (aclk),
        .cmd     (cmd),
        .range_i (range_reg),
        .angle_i (angle_reg),
        .point_x (cx),
        .point_y (cy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_x_reg    <= keep_reg ? cx : '0;
            out_y_reg    <= keep_reg ? cy : '0;
            out_keep_reg <= keep_reg;
            out_last_reg <= last_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({out_y_reg, out_x_reg});
    assign m_axis_tuser  = out_keep_reg;
    assign m_axis_tlast  = out_last_reg;

`ifndef SYNTH
    a_scan_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_fire && s_axis_tlast) |=> (offset_reg == '0))
        else $error("beam offset not cleared after end of scan");

    a_dropped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("dropped sample carries nonzero coordinates");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_valid_reg || m_axis_tready))
        else $error("output register overwritten before its beat was taken");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load || cmd.rot) |-> !s_axis_tready)
        else $error("input ready while a sample is being rotated");
`endif

endmodule

>>> tb/tb_top.sv
// Testbench for laser_scan_polar_to_cartesian_top: random scans with bursty input
// and a stalling receiver, checked beat by beat against a CORDIC point predictor.
// Depends on lspc_pkg and the block's RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import lspc_pkg::*;

    localparam int     RNG_W      = 20;
    localparam int     ANG_W      = 24;
    localparam int     PT_W       = RNG_W + 1;
    localparam int     ROT_STEPS  = 20;
    localparam int     WDOG_LIMIT = 2000;
    localparam longint OUT_LIM    = (64'sd1 <<< RNG_W) - 1;
    localparam longint INV_GAIN   = 64'd2608131496;   // 1/K scaled by 2^32

    // atan(2^-i) in 2^-32 turn
    localparam longint ATAN_Q32 [ROT_STEPS] = '{
        64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
        64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
        64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
        64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
        64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518
    };

    class scan_point_scoreboard;
        typedef struct {
            bit [PT_W-1:0] x;
            bit [PT_W-1:0] y;
            bit            valid;
            bit            last;
        } point_t;

        point_t          expected_points[$];
        bit [ANG_W-1:0]  start_angle;
        bit [ANG_W-1:0]  angle_incr;
        bit [ANG_W-1:0]  beam_offset;
        bit [RNG_W-1:0]  min_range;
        bit [RNG_W-1:0]  max_range;
        int              errors;

        function new();
            start_angle = '0;
            angle_incr  = '0;
            beam_offset = '0;
            min_range   = '0;
            max_range   = '1;
            errors      = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, bit [ANG_W-1:0] value);
            case (idx)
                REG_START_ANGLE: start_angle = value;
                REG_ANGLE_STEP:  angle_incr  = value;
                REG_MIN_RANGE:   min_range   = value[RNG_W-1:0];
                REG_MAX_RANGE:   max_range   = value[RNG_W-1:0];
                default: ;
            endcase
        endfunction

        // drop guard bits with round-half-up, clamp to the symmetric output range
        function bit [PT_W-1:0] round_sat(longint v);
            longint r;
            r = (v + 64'sd32768) >>> 16;
            if (r > OUT_LIM) r = OUT_LIM;
            if (r < -OUT_LIM) r = -OUT_LIM;
            return PT_W'(r);
        endfunction

        function void note_sample(bit [RNG_W-1:0] r, bit not_finite, bit last);
            point_t         p;
            bit [ANG_W-1:0] beam_angle;
            bit [31:0]      a32;
            bit [31:0]      shifted;
            bit [31:0]      res;
            bit [1:0]       quad;
            longint         x, y, z, dx, dy, px, py;
            int             i;
            beam_angle = start_angle + beam_offset;
            p.valid = !not_finite && r >= min_range && r <= max_range;
            p.last  = last;
            p.x     = '0;
            p.y     = '0;
            if (p.valid) begin
                // nearest quarter turn, residual within +-1/8 turn
                a32     = {beam_angle, 8'h00};
                shifted = a32 + 32'h2000_0000;
                quad    = shifted[31:30];
                res     = a32 - {quad, 30'd0};
                z       = $signed(res);
                x       = longint'((64'(r) * INV_GAIN) >> 16);
                y       = 0;
                for (i = 0; i < ROT_STEPS; i++) begin
                    dx = y >>> i;
                    dy = x >>> i;
                    if (z >= 0) begin
                        x -= dx;
                        y += dy;
                        z -= ATAN_Q32[i];
                    end else begin
                        x += dx;
                        y -= dy;
                        z += ATAN_Q32[i];
                    end
                end
                case (quad)
                    2'd0: begin px = x;  py = y;  end
                    2'd1: begin px = -y; py = x;  end
                    2'd2: begin px = -x; py = -y; end
                    default: begin px = y; py = -x; end
                endcase
                p.x = round_sat(px);
                p.y = round_sat(py);
            end
            expected_points = {expected_points, p};
            beam_offset = last ? '0 : beam_offset + angle_incr;
        endfunction

        function void check_point(logic [PT_W-1:0] x, logic [PT_W-1:0] y,
                                  logic valid, logic last);
            point_t e;
            if (expected_points.size() == 0) begin
                $error("point beat with no sample pending");
                errors++;
                return;
            end
            e = expected_points.pop_front();
            if (x !== e.x) begin
                $error("point_x mismatch: expected %0d, got %0d", $signed(e.x), $signed(x));
                errors++;
            end
            if (y !== e.y) begin
                $error("point_y mismatch: expected %0d, got %0d", $signed(e.y), $signed(y));
                errors++;
            end
            if (valid !== e.valid) begin
                $error("point_valid mismatch: expected %0d, got %0d", e.valid, valid);
                errors++;
            end
            if (last !== e.last) begin
                $error("point_last mismatch: expected %0d, got %0d", e.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_wr_en     = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr      = '0;
    logic [ANG_W-1:0]      cfg_wdata     = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [23:0]           s_axis_tdata  = '0;   // range_value
    logic                  s_axis_tuser  = 1'b0; // not_finite
    logic                  s_axis_tlast  = 1'b0; // scan_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [47:0]           m_axis_tdata;         // point_x, point_y
    logic                  m_axis_tuser;         // point_valid
    logic                  m_axis_tlast;         // point_last

    scan_point_scoreboard  board = new();
    int                    rdy_mode    = 0;
    int                    stall_left  = 0;
    int                    idle_cycles = 0;

    laser_scan_polar_to_cartesian_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 aclk = ~aclk;

    // receiver: always ready, coin-flip, or mostly ready with long stalls
    always @(posedge aclk) begin
        if (stall_left != 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            case (rdy_mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                default: begin
                    if ($urandom_range(0, 15) == 0) begin
                        stall_left    <= $urandom_range(10, 60);
                        m_axis_tready <= 1'b0;
                    end else begin
                        m_axis_tready <= 1'b1;
                    end
                end
            endcase
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready)
            board.check_point(m_axis_tdata[PT_W-1:0], m_axis_tdata[2*PT_W-1:PT_W],
                              m_axis_tuser, m_axis_tlast);
    end

    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [ANG_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        board.write_reg(idx, value);
    endtask

    task automatic configure(logic [ANG_W-1:0] start, logic [ANG_W-1:0] incr,
                             logic [RNG_W-1:0] lo, logic [RNG_W-1:0] hi);
        write_reg(REG_START_ANGLE, start);
        write_reg(REG_ANGLE_STEP, incr);
        write_reg(REG_MIN_RANGE, ANG_W'(lo));
        write_reg(REG_MAX_RANGE, ANG_W'(hi));
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic send_sample(bit [RNG_W-1:0] r, bit not_finite, bit last);
        s_axis_tdata  <= 24'(r);
        s_axis_tuser  <= not_finite;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_axis_tready);
        board.note_sample(r, not_finite, last);
    endtask

    task automatic pause_sender(int n);
        if (n > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (board.expected_points.size() != 0) @(posedge aclk);
    endtask

    // bias ranges toward the window edges and the field extremes
    function automatic bit [RNG_W-1:0] pick_range();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return board.min_range + RNG_W'($urandom_range(0, 2)) - 1'b1;
            3: return board.max_range + RNG_W'($urandom_range(0, 2)) - 1'b1;
            4, 5: return RNG_W'($urandom_range(0, 65535));
            default: return RNG_W'($urandom);
        endcase
    endfunction

    task automatic random_setup();
        logic [ANG_W-1:0] start, incr;
        logic [RNG_W-1:0] lo, hi;
        start = ANG_W'($urandom);
        case ($urandom_range(0, 4))
            0: incr = ANG_W'($urandom_range(0, 4096));
            1: incr = -ANG_W'($urandom_range(0, 4096));
            2: incr = ANG_W'($urandom);
            3: incr = $urandom_range(0, 1) ? 24'h800000 : 24'h7FFFFF;
            default: incr = '0;
        endcase
        case ($urandom_range(0, 5))
            0: begin lo = '0; hi = '1; end
            1: begin
                lo = RNG_W'($urandom_range(0, 16383));
                hi = RNG_W'($urandom_range(500000, 1048575));
            end
            2: begin   // empty window, everything dropped
                lo = RNG_W'($urandom_range(1, 1048575));
                hi = RNG_W'($urandom_range(0, lo - 1));
            end
            3: begin
                lo = RNG_W'($urandom_range(0, 1000000));
                hi = lo + RNG_W'($urandom_range(0, 40000));
            end
            default: begin
                lo = RNG_W'($urandom_range(0, 65535));
                hi = RNG_W'($urandom);
            end
        endcase
        rdy_mode = $urandom_range(0, 2);
        configure(start, incr, lo, hi);
    endtask

    task automatic run_scans(int n_items);
        int scan_len, beam_idx, burst_left, gap_max;
        bit last;
        scan_len   = $urandom_range(3, 60);
        beam_idx   = 0;
        burst_left = 0;
        gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 30;
        repeat (n_items) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max));
            end
            burst_left--;
            beam_idx++;
            // mostly whole scans, now and then a scan cut short
            last = (beam_idx >= scan_len) || ($urandom_range(0, 49) == 0);
            if (last) begin
                beam_idx = 0;
                scan_len = $urandom_range(3, 60);
            end
            send_sample(pick_range(), $urandom_range(0, 9) == 0, last);
        end
        drain();
    endtask

    initial begin
        int k;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        rdy_mode = 1;

        // register defaults: full window, beam angle zero
        send_sample('0, 1'b0, 1'b0);
        send_sample('1, 1'b0, 1'b0);
        send_sample(20'd12345, 1'b1, 1'b0);
        send_sample(20'd4096, 1'b0, 1'b1);
        drain();

        // half-turn start with max step: offset wraps; samples at and below min
        configure(24'h800000, 24'h7FFFFF, 20'd4096, 20'hFFFFF);
        send_sample(20'd4095, 1'b0, 1'b0);
        send_sample(20'd4096, 1'b0, 1'b0);
        send_sample('1, 1'b0, 1'b0);
        send_sample(20'h80000, 1'b1, 1'b0);
        send_sample(20'h80000, 1'b0, 1'b1);
        drain();

        // min above max
        configure(24'h7FFFFF, 24'h800000, 20'hFFFFF, 20'd0);
        send_sample('0, 1'b0, 1'b0);
        send_sample('1, 1'b0, 1'b0);
        send_sample(20'd777, 1'b0, 1'b1);
        drain();

        // beams on the eighth-turn boundaries, walking through every quadrant
        configure(24'h200000, 24'h400000, 20'd0, 20'hFFFFF);
        for (k = 0; k < 6; k++)
            send_sample(20'd100000 + RNG_W'(k), 1'b0, k == 5);
        drain();

        repeat (8) begin
            random_setup();
            run_scans(100);
        end

        repeat (30) @(posedge aclk);
        if (board.errors == 0 && board.expected_points.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
